### hw/rtl/rms_pkg.sv
// shared types and command codes for the reachability mark and sweep core
package rms_pkg;

    // command codes of an input beat
    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_COLLECT = 2'd2
    } cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE_WR,
        ST_MARK,
        ST_SWEEP
    } state_t;

endpackage

### hw/rtl/reachability_mark_sweep_core.sv
// reachability tracker: adjacency rows in a memory, mark and sweep collection
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_valid / s_ready  | s_command, s_from_node, s_to_node, s_root_mask
//  m_      | out | m_valid / m_ready  | m_live_mask (collect only)
//
// insert and remove edge read the row, then write the row back.
// in collect, the mark loop reads one adjacency row per cycle through the single
// memory read port.
// reset clears per-row valid bits at once, so no clearing pass is needed.
// a finished result waits in the output register while edge commands go on;
// a further collect holds in its sweep until the previous result is taken.
module reachability_mark_sweep_core
    import rms_pkg::*;
#(
    parameter int NODE_SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [5:0]  s_from_node,
    input  logic [5:0]  s_to_node,
    input  logic [63:0] s_root_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_live_mask
);

    localparam int IDX_W = $clog2(NODE_SLOTS);

    typedef logic [NODE_SLOTS-1:0] row_t;
    typedef logic [IDX_W-1:0]      idx_t;

    // state and control registers
    state_t      state_reg, state_next;
    row_t        present_reg, present_next;
    row_t        row_valid_reg, row_valid_next;
    row_t        mark_reg, mark_next;
    row_t        pending_reg, pending_next;
    logic        issue_reg, issue_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_live_mask_reg, m_live_mask_next;

    // captured edge command
    logic        cmd_insert_reg, cmd_insert_next;
    idx_t        src_reg, src_next;
    idx_t        dst_reg, dst_next;

    // adjacency memory
    row_t        row_mem [NODE_SLOTS];
    row_t        rd_data_reg;
    idx_t        rd_addr;
    logic        wr_en;
    idx_t        wr_addr;
    row_t        wr_data;

    // mark loop work signals
    row_t        row_in;
    row_t        work;
    row_t        low_bit;
    idx_t        low_idx;
    row_t        old_row;
    row_t        dst_bit;

    logic        accept;
    logic        edge_in_range;
    logic        out_free;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_live_mask = m_live_mask_reg;
    assign out_free    = !m_valid_reg || m_ready;

    assign edge_in_range = ({1'b0, s_from_node} < 7'(NODE_SLOTS))
                        && ({1'b0, s_to_node} < 7'(NODE_SLOTS));

    // row returned by last cycle's read, kept only if it belongs to a live row
    assign row_in  = issue_reg ? rd_data_reg : '0;
    assign work    = (pending_reg | row_in) & ~mark_reg;
    assign low_bit = work & (~work + row_t'(1));

    // one-hot to index of the lowest pending slot
    always_comb begin
        low_idx = '0;
        for (int i = 0; i < NODE_SLOTS; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | idx_t'(i);
            end
        end
    end

    // edge row read-modify-write operands
    assign old_row = row_valid_reg[src_reg] ? rd_data_reg : '0;
    assign dst_bit = row_t'(1) << dst_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_COLLECT) begin
                        state_next = ST_MARK;
                    end else if ((s_command == CMD_INSERT || s_command == CMD_REMOVE)
                                 && edge_in_range) begin
                        state_next = ST_EDGE_WR;
                    end
                end
            end
            ST_EDGE_WR: state_next = ST_IDLE;
            ST_MARK: begin
                if (work == '0) begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs per state
    always_comb begin
        present_next     = present_reg;
        row_valid_next   = row_valid_reg;
        mark_next        = mark_reg;
        pending_next     = pending_reg;
        issue_next       = 1'b0;
        cmd_insert_next  = cmd_insert_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_live_mask_next = m_live_mask_reg;
        rd_addr          = src_reg;
        wr_en            = 1'b0;
        wr_addr          = src_reg;
        wr_data          = old_row;
        case (state_reg)
            ST_IDLE: begin
                rd_addr = s_from_node[IDX_W-1:0];
                if (accept) begin
                    cmd_insert_next = (s_command == CMD_INSERT);
                    src_next        = s_from_node[IDX_W-1:0];
                    dst_next        = s_to_node[IDX_W-1:0];
                    mark_next       = '0;
                    pending_next    = s_root_mask[NODE_SLOTS-1:0];
                end
            end
            ST_EDGE_WR: begin
                // insert sets both ends present; remove acts only on a present source
                if (cmd_insert_reg) begin
                    wr_en                   = 1'b1;
                    wr_data                 = old_row | dst_bit;
                    row_valid_next[src_reg] = 1'b1;
                    present_next            = present_reg | dst_bit
                                            | (row_t'(1) << src_reg);
                end else if (present_reg[src_reg]) begin
                    wr_en                   = 1'b1;
                    wr_data                 = old_row & ~dst_bit;
                    row_valid_next[src_reg] = 1'b1;
                end
            end
            ST_MARK: begin
                // take the lowest unmarked pending slot and fetch its row
                rd_addr = low_idx;
                if (work != '0) begin
                    mark_next    = mark_reg | low_bit;
                    pending_next = work & ~low_bit;
                    issue_next   = present_reg[low_idx] && row_valid_reg[low_idx];
                end else begin
                    pending_next = '0;
                end
            end
            ST_SWEEP: begin
                // drop unmarked slots; a row is only valid while its slot is present
                if (out_free) begin
                    present_next     = present_reg & mark_reg;
                    row_valid_next   = row_valid_reg & mark_reg;
                    m_valid_next     = 1'b1;
                    m_live_mask_next = 64'(mark_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            present_reg   <= '0;
            row_valid_reg <= '0;
            mark_reg      <= '0;
            pending_reg   <= '0;
            issue_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            row_valid_reg <= row_valid_next;
            mark_reg      <= mark_next;
            pending_reg   <= pending_next;
            issue_reg     <= issue_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_insert_reg  <= cmd_insert_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        m_live_mask_reg <= m_live_mask_next;
    end

    // adjacency memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= row_mem[rd_addr];
    end

`ifndef SYNTHESIS
    // marks only grow while the mark loop runs
    a_mark_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MARK) |=> ((mark_reg & $past(mark_reg)) == $past(mark_reg)))
        else $error("mark set lost a slot during mark loop");

    // a valid row always belongs to a present slot
    a_valid_present: assert property (@(posedge aclk) disable iff (!aresetn)
        ((row_valid_reg & ~present_reg) == '0))
        else $error("valid row on absent slot");

    // a result only appears out of the sweep
    a_result_from_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_SWEEP))
        else $error("result raised outside sweep");
`endif

endmodule

### test/testbench.sv
// testbench for the reachability mark and sweep core: directed table, then random beats
module testbench
    import rms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODE_SLOTS = 64;
    localparam logic [63:0] SLOT_BITS = (NODE_SLOTS >= 64) ? '1 :
                                        ((64'd1 << NODE_SLOTS) - 64'd1);
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int BEATS_PER_PHASE = 205;

    // one row of the directed table
    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [63:0] roots;
        logic        typed;
        logic [63:0] want;
    } step_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [5:0]  s_from_node;
    logic [5:0]  s_to_node;
    logic [63:0] s_root_mask;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_live_mask;

    // predictor state: presence bits and adjacency rows
    logic [63:0] present_bits;
    logic [63:0] adj_rows [64];

    logic [63:0] live_q [$];
    logic [63:0] want_mask;
    int          errors;
    bit          burst_mode;
    bit          hold_off_req;
    int          win_base;
    int          win_size;

    reachability_mark_sweep_core #(
        .NODE_SLOTS(NODE_SLOTS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_from_node (s_from_node),
        .s_to_node   (s_to_node),
        .s_root_mask (s_root_mask),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_live_mask (m_live_mask)
    );

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // apply one accepted command to the predictor; returns 1 when a live mask is due
    function automatic bit track_command(input logic [1:0] cmd, input logic [5:0] src,
            input logic [5:0] dst, input logic [63:0] roots, output logic [63:0] live);
        logic [63:0] marks;
        logic [63:0] grown;
        live = '0;
        if (cmd == CMD_INSERT || cmd == CMD_REMOVE) begin
            if (src >= NODE_SLOTS || dst >= NODE_SLOTS)
                return 1'b0;
            if (cmd == CMD_INSERT) begin
                present_bits[src] = 1'b1;
                present_bits[dst] = 1'b1;
                adj_rows[src][dst] = 1'b1;
            end else if (present_bits[src]) begin
                adj_rows[src][dst] = 1'b0;
            end
            return 1'b0;
        end
        if (cmd != CMD_COLLECT)
            return 1'b0;
        // mark: grow the root set through rows of present slots until it settles
        grown = roots & SLOT_BITS;
        do begin
            marks = grown;
            for (int i = 0; i < NODE_SLOTS; i++)
                if (marks[i] && present_bits[i])
                    grown |= adj_rows[i] & SLOT_BITS;
        end while (grown != marks);
        // sweep: drop present slots that were not reached
        for (int i = 0; i < NODE_SLOTS; i++) begin
            if (present_bits[i] && !marks[i]) begin
                present_bits[i] = 1'b0;
                adj_rows[i] = '0;
            end
        end
        live = marks;
        return 1'b1;
    endfunction

    function automatic int idle_gap();
        return burst_mode ? 0 : $urandom_range(0, 10);
    endfunction

    // random set bit of v, or -1 when v is empty
    function automatic int random_member(input logic [63:0] v);
        int start;
        start = $urandom_range(0, 63);
        for (int k = 0; k < 64; k++)
            if (v[(start + k) % 64])
                return (start + k) % 64;
        return -1;
    endfunction

    // node slot, mostly from the current window so that graphs get dense
    function automatic logic [5:0] pick_node();
        if ($urandom_range(0, 3) == 0)
            return 6'($urandom_range(0, 63));
        return 6'((win_base + $urandom_range(0, win_size - 1)) % 64);
    endfunction

    function automatic step_row_t row(input logic [1:0] cmd, input logic [5:0] src,
            input logic [5:0] dst, input logic [63:0] roots, input logic typed,
            input logic [63:0] want);
        return '{cmd: cmd, src: src, dst: dst, roots: roots, typed: typed, want: want};
    endfunction

    // offer one input beat and wait for it to be taken; called and returns at a falling edge
    task automatic offer_beat(input logic [1:0] cmd, input logic [5:0] src,
            input logic [5:0] dst, input logic [63:0] roots, input logic typed,
            input logic [63:0] want);
        int gap;
        logic [63:0] live;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_from_node <= src;
        s_to_node   <= dst;
        s_root_mask <= roots;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (track_command(cmd, src, dst, roots, live))
            live_q.push_back(typed ? want : live);
        @(negedge aclk);
    endtask

    // result receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            gap = idle_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
        end
    end

    // check each live mask beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (live_q.size() == 0) begin
                errors++;
                $display("%0t: live mask beat with none expected: actual %h",
                         $time, m_live_mask);
            end else begin
                want_mask = live_q.pop_front();
                if (m_live_mask !== want_mask) begin
                    errors++;
                    $display("%0t: live mask mismatch: expected %h actual %h",
                             $time, want_mask, m_live_mask);
                end
            end
        end
    end

    // run limit
    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    // stimulus
    initial begin
        step_row_t   steps [$];
        int          sel;
        int          idx;
        int          sent;
        int          sizes [RANDOM_PHASES];
        logic [1:0]  cmd;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [63:0] roots;

        errors       = 0;
        burst_mode   = 1'b0;
        hold_off_req = 1'b0;
        win_base     = 0;
        win_size     = 64;
        present_bits = '0;
        for (int i = 0; i < 64; i++)
            adj_rows[i] = '0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_command   = CMD_INSERT;
        s_from_node = '0;
        s_to_node   = '0;
        s_root_mask = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        steps.push_back(row(CMD_COLLECT, 0, 0, 64'h0, 1'b1, 64'h0));
        // absent roots are reported live
        steps.push_back(row(CMD_COLLECT, 0, 0, '1, 1'b1, '1));
        steps.push_back(row(CMD_INSERT, 0, 63, '0, 1'b0, '0));
        steps.push_back(row(CMD_INSERT, 63, 0, '0, 1'b0, '0));
        steps.push_back(row(CMD_INSERT, 63, 63, '0, 1'b0, '0));
        steps.push_back(row(CMD_COLLECT, 0, 0, 64'h1, 1'b1, 64'h8000_0000_0000_0001));
        // remove with an absent source does nothing
        steps.push_back(row(CMD_REMOVE, 5, 6, '0, 1'b0, '0));
        steps.push_back(row(CMD_INSERT, 1, 2, '0, 1'b0, '0));
        steps.push_back(row(CMD_INSERT, 2, 3, '0, 1'b0, '0));
        steps.push_back(row(CMD_UNUSED, 63, 63, '1, 1'b0, '0));
        steps.push_back(row(CMD_COLLECT, 0, 0, 64'h1, 1'b0, '0));
        // slot 1 was swept, so it comes back as an absent root
        steps.push_back(row(CMD_COLLECT, 0, 0, 64'h2, 1'b1, 64'h2));
        steps.push_back(row(CMD_INSERT, 10, 20, '0, 1'b0, '0));
        steps.push_back(row(CMD_REMOVE, 10, 20, '0, 1'b0, '0));
        steps.push_back(row(CMD_COLLECT, 0, 0, 64'h401, 1'b0, '0));
        steps.push_back(row(CMD_INSERT, 40, 41, '0, 1'b0, '0));
        steps.push_back(row(CMD_INSERT, 41, 42, '0, 1'b0, '0));
        steps.push_back(row(CMD_INSERT, 42, 40, '0, 1'b0, '0));
        steps.push_back(row(CMD_REMOVE, 63, 0, '0, 1'b0, '0));
        steps.push_back(row(CMD_COLLECT, 0, 0, 64'h8000_0100_0000_0000, 1'b0, '0));
        steps.push_back(row(CMD_COLLECT, 0, 0, 64'h0, 1'b1, 64'h0));
        steps.push_back(row(CMD_COLLECT, 0, 0, 64'h8000_0000_0000_0000, 1'b1,
                            64'h8000_0000_0000_0000));
        steps.push_back(row(CMD_UNUSED, 0, 0, '0, 1'b0, '0));
        foreach (steps[i])
            offer_beat(steps[i].cmd, steps[i].src, steps[i].dst, steps[i].roots,
                       steps[i].typed, steps[i].want);

        // random phases, each with its own window of node slots
        sizes = '{4, 8, 64, 16, 2, 32, 64, 6};
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            win_base   = $urandom_range(0, 63);
            win_size   = sizes[phase];
            burst_mode = (phase == 2 || phase == 5);
            // long receiver hold-off while beats keep coming
            if (phase == 3)
                hold_off_req = 1'b1;
            sent = 0;
            while (sent < BEATS_PER_PHASE) begin
                sel   = $urandom_range(0, 99);
                src   = pick_node();
                dst   = pick_node();
                roots = {$urandom, $urandom};
                if (sel < 55) begin
                    cmd = CMD_INSERT;
                end else if (sel < 73) begin
                    cmd = CMD_REMOVE;
                    idx = random_member(present_bits);
                    if ($urandom_range(0, 1) == 0 && idx >= 0 && adj_rows[idx] != '0) begin
                        src = 6'(idx);
                        dst = 6'(random_member(adj_rows[idx]));
                    end
                end else if (sel < 88) begin
                    cmd = CMD_COLLECT;
                    sel = $urandom_range(0, 19);
                    if (sel < 2) begin
                        roots = '0;
                    end else if (sel < 3) begin
                        roots = '1;
                    end else if (sel < 6) begin
                        roots = {$urandom, $urandom};
                    end else if (sel < 10) begin
                        roots = present_bits & {$urandom, $urandom} & {$urandom, $urandom};
                    end else begin
                        idx   = random_member(present_bits);
                        roots = (idx >= 0) ? (64'd1 << idx) : (64'd1 << pick_node());
                    end
                end else if (sel < 92) begin
                    cmd = CMD_UNUSED;
                end else begin
                    cmd = 2'($urandom_range(0, 3));
                end
                offer_beat(cmd, src, dst, roots, 1'b0, '0);
                sent++;
            end
            // sender pause until every live mask is back
            s_valid <= 1'b0;
            @(negedge aclk);
            while (live_q.size() != 0)
                @(negedge aclk);
        end

        // drain
        s_valid <= 1'b0;
        while (live_q.size() != 0)
            @(negedge aclk);
        repeat (NODE_SLOTS + 16) @(negedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rms_pkg.sv
hw/rtl/reachability_mark_sweep_core.sv
test/testbench.sv
